// ===== rtl/byte_deque_indexed_top_macros.svh =====
`ifndef BYTE_DEQUE_INDEXED_TOP_MACROS_SVH
`define BYTE_DEQUE_INDEXED_TOP_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam logic [2:0] KIND_PUSH     = 3'd0;
  localparam logic [2:0] KIND_POP_TOP  = 3'd1;
  localparam logic [2:0] KIND_POP_BOT  = 3'd2;
  localparam logic [2:0] KIND_REMOVE   = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [3:0] index;
  } item_t;

  typedef struct packed {
    logic [7:0] result_value;
    logic [1:0] status;
    logic [4:0] entry_count;
  } result_t;

endpackage

// ===== rtl/bdq_store.sv =====
`include "byte_deque_indexed_top_macros.svh"

module bdq_store #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             op_en,
  input  bdq_pkg::item_t   op,
  output bdq_pkg::result_t res
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > 4) ? CW : 4;

  logic [7:0]    cells [DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          full;
  logic          empty;
  logic          in_range;
  logic          wr;
  logic          rm;
  logic [AW-1:0] pos;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign in_range = (CMPW'(op.index) < CMPW'(count));

  always_comb begin
    wr               = 1'b0;
    rm               = 1'b0;
    pos              = AW'(op.index);
    res.result_value = 8'd0;
    res.status       = bdq_pkg::ST_MISS;
    unique case (op.kind)
      bdq_pkg::KIND_PUSH: begin
        if (!full) begin
          wr               = 1'b1;
          res.result_value = op.value;
          res.status       = bdq_pkg::ST_OK;
        end else begin
          res.status = bdq_pkg::ST_FULL;
        end
      end
      bdq_pkg::KIND_POP_TOP: begin
        pos = AW'(count - CW'(1));
        if (!empty) begin
          rm = 1'b1;
        end
      end
      bdq_pkg::KIND_POP_BOT: begin
        pos = '0;
        if (!empty) begin
          rm = 1'b1;
        end
      end
      bdq_pkg::KIND_REMOVE: begin
        if (in_range) begin
          rm = 1'b1;
        end
      end
      bdq_pkg::KIND_READ: begin
        if (in_range) begin
          res.result_value = cells[pos];
          res.status       = bdq_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
    if (rm) begin
      res.result_value = cells[pos];
      res.status       = bdq_pkg::ST_OK;
    end
    count_next = count;
    if (wr) begin
      count_next = count + CW'(1);
    end else if (rm) begin
      count_next = count - CW'(1);
    end
    res.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (op_en) begin
      count <= count_next;
    end
  end

  // cells above the removed position move down one place
  always_ff @(posedge clk) begin
    if (op_en && wr) begin
      cells[AW'(count)] <= op.value;
    end else if (op_en && rm) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (AW'(i) >= pos) begin
          cells[i] <= cells[i + 1];
        end
      end
    end
  end

  `BDQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "count beyond depth")
  `BDQ_ASSERT_NEXT(a_push_grows, op_en && wr, count == $past(count) + CW'(1), "push lost")
  `BDQ_ASSERT_NEXT(a_fail_holds, op_en && res.status != bdq_pkg::ST_OK,
                   count == $past(count), "failed op changed count")

endmodule

// ===== rtl/byte_deque_indexed_top.sv =====
// an accepted item passes the input register and then the result register before its result is valid
// throughput: one item per cycle when the result side does not stall
// the input register feeds the cell store and its result register in one pass
// reset clears the entry count and both valid flags
// cell contents are not cleared; only cells below the count are ever read
`include "byte_deque_indexed_top_macros.svh"

module byte_deque_indexed_top #(
  parameter int DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bdq_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bdq_pkg::result_t result
);

  logic             held_valid;
  bdq_pkg::item_t   held;
  logic             adv;
  logic             op_en;
  bdq_pkg::result_t store_res;

  assign adv        = !result_valid || !result_stall;
  assign item_stall = held_valid && !adv;
  assign op_en      = held_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  bdq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .rst  (rst),
    .op_en(op_en),
    .op   (held),
    .res  (store_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_en) begin
      result <= store_res;
    end
  end

  `BDQ_ASSERT_NEXT(a_op_gives_result, op_en, result_valid, "processed item gave no result")
  `BDQ_ASSERT_NOW(a_full_count, result_valid && result.status == bdq_pkg::ST_FULL,
                  result.entry_count == 5'(DEPTH), "full flag with short count")
  `BDQ_ASSERT_NOW(a_fail_zero, result_valid && result.status != bdq_pkg::ST_OK,
                  result.result_value == 8'd0, "failed op returned a byte")

endmodule
